[hw/rtl/sgm_pkg.sv]
package sgm_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int ADDR_W      = 11;
   localparam int PIX_W       = 8;
   localparam int ROW_W       = 12;
   localparam int COL_W       = 11;
   localparam int CFG_W       = 12;
   localparam int WIN_TAPS    = 9;

   localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd2048;
   localparam logic [CFG_W-1:0] WIDTH_MIN   = 12'd3;
   localparam logic [CFG_W-1:0] WIDTH_MAX   = 12'd2048;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // window tap k = row * 3 + column, row 0 is the oldest line, column 0 the oldest pixel
   typedef struct packed {
      logic [WIN_TAPS-1:0][PIX_W-1:0] win;
      logic [ROW_W-1:0]               row;
      logic [COL_W-1:0]               col;
   } window_item_type;

   typedef struct packed {
      logic                    valid;
      logic [QCNT_W-1:0]       count;
   } queue_status_type;

endpackage

[hw/rtl/sgm_ram.sv]
module sgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sgm_front.sv]
module sgm_front import sgm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_tvalid,
   output logic             csr_tready,
   input  logic [15:0]      csr_tdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tuser,
   input  queue_status_type q_status,
   output logic             q_push,
   output window_item_type  q_item
);

   logic [CFG_W-1:0]  width_ff, width_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              s2_valid_ff;
   logic              s2_emit_ff;
   logic [COL_W-1:0]  s2_col_ff;
   logic [ROW_W-1:0]  s2_row_ff;
   logic [PIX_W-1:0]  s2_pix_ff;
   logic              fwd_ff;
   logic [PIX_W-1:0]  fwd_up_ff, fwd_mid_ff;
   logic [WIN_TAPS-1:0][PIX_W-1:0] win_ff, win_in;

   logic [CFG_W-1:0]  eff_w;
   logic              accept;
   logic [ROW_W-1:0]  row0, r;
   logic [COL_W-1:0]  col0, c;
   logic [CFG_W-1:0]  c_plus;
   logic [PIX_W-1:0]  ram_up, ram_mid, up, mid;

   assign csr_tready = 1'b1;
   assign width_in   = (csr_tvalid) ? csr_tdata[CFG_W-1:0] : width_ff;

   assign eff_w = (width_ff < WIDTH_MIN) ? WIDTH_MIN :
                  (width_ff > WIDTH_MAX) ? WIDTH_MAX : width_ff;

   // room for the item in flight plus this one
   assign req_tready = ({1'b0, q_status.count} + {{QCNT_W{1'b0}}, s2_valid_ff})
                       < (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      row0 = req_tuser ? '0 : row_ff;
      col0 = req_tuser ? '0 : col_ff;
      if ({1'b0, col0} >= eff_w) begin
         c = '0;
         r = row0 + 1'b1;
      end else begin
         c = col0;
         r = row0;
      end
      c_plus = {1'b0, c} + 1'b1;
      if (c_plus >= eff_w) begin
         col_in = '0;
         row_in = r + 1'b1;
      end else begin
         col_in = c_plus[COL_W-1:0];
         row_in = r;
      end
   end

   sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_col_ff),
      .wr_data (mid),
      .rd_en   (accept),
      .rd_addr (c),
      .rd_data (ram_up)
   );

   sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_col_ff),
      .wr_data (s2_pix_ff),
      .rd_en   (accept),
      .rd_addr (c),
      .rd_data (ram_mid)
   );

   // same column read while it is written: take the new values
   assign up  = fwd_ff ? fwd_up_ff  : ram_up;
   assign mid = fwd_ff ? fwd_mid_ff : ram_mid;

   always_comb begin
      win_in = win_ff;
      if (s2_valid_ff) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = up;
         win_in[3] = win_ff[4];
         win_in[4] = win_ff[5];
         win_in[5] = mid;
         win_in[6] = win_ff[7];
         win_in[7] = win_ff[8];
         win_in[8] = s2_pix_ff;
      end
   end

   assign q_push     = s2_valid_ff && s2_emit_ff;
   assign q_item.win = win_in;
   assign q_item.row = s2_row_ff - 1'b1;
   assign q_item.col = s2_col_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         s2_valid_ff <= accept;
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (accept) begin
         s2_col_ff  <= c;
         s2_row_ff  <= r;
         s2_pix_ff  <= req_tdata;
         s2_emit_ff <= (r >= ROW_W'(2)) && (c >= COL_W'(2));
         fwd_ff     <= s2_valid_ff && (s2_col_ff == c);
         fwd_up_ff  <= mid;
         fwd_mid_ff <= s2_pix_ff;
      end
   end

endmodule

[hw/rtl/sgm_queue.sv]
module sgm_queue import sgm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  window_item_type  push_item,
   input  logic             pop,
   output window_item_type  head_item,
   output queue_status_type status
);

   window_item_type   slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + {{(QCNT_W-1){1'b0}}, push} - {{(QCNT_W-1){1'b0}}, pop};
      end
   end

   assign head_item    = slot_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.count = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != QCNT_W'(QUEUE_DEPTH)))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue pop while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");

endmodule

[hw/rtl/sgm_back.sv]
module sgm_back import sgm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  window_item_type  q_item,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [PIX_W-1:0] rsp_mag,
   output logic [ROW_W-1:0] rsp_row,
   output logic [COL_W-1:0] rsp_col
);

   logic              en;
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic [7:0]        ax_ff, ay_ff;
   logic [16:0]       sum_ff;
   logic              sat_ff;
   logic [15:0]       rem_ff;
   logic [16:0]       res_ff;
   logic [PIX_W-1:0]  mag_ff;
   logic [ROW_W-1:0]  row1_ff, row2_ff, row3_ff, row4_ff;
   logic [COL_W-1:0]  col1_ff, col2_ff, col3_ff, col4_ff;

   logic signed [10:0] sx, sy;
   logic signed [10:0] qx, qy;
   logic [15:0]        rem_a, rem_b;
   logic [16:0]        res_a, res_b;
   logic [16:0]        trial_a, trial_b;

   assign en    = !v4_ff || rsp_tready;
   assign q_pop = en && q_valid;

   // sobel sums over the window
   always_comb begin
      sx = $signed({3'b0, q_item.win[0]}) + $signed({2'b0, q_item.win[3], 1'b0})
         + $signed({3'b0, q_item.win[6]}) - $signed({3'b0, q_item.win[2]})
         - $signed({2'b0, q_item.win[5], 1'b0}) - $signed({3'b0, q_item.win[8]});
      sy = $signed({3'b0, q_item.win[6]}) + $signed({2'b0, q_item.win[7], 1'b0})
         + $signed({3'b0, q_item.win[8]}) - $signed({3'b0, q_item.win[0]})
         - $signed({2'b0, q_item.win[1], 1'b0}) - $signed({3'b0, q_item.win[2]});
      // divide by 4 toward zero
      qx = sx[10] ? ((sx + 11'sd3) >>> 2) : (sx >>> 2);
      qy = sy[10] ? ((sy + 11'sd3) >>> 2) : (sy >>> 2);
   end

   // integer square root, four result bits per stage
   always_comb begin
      rem_a = sum_ff[15:0];
      res_a = '0;
      trial_a = '0;
      for (int k = 0; k < 4; k++) begin
         trial_a = res_a + (17'd1 << (14 - 2 * k));
         if ({1'b0, rem_a} >= trial_a) begin
            rem_a = rem_a - trial_a[15:0];
            res_a = (res_a >> 1) + (17'd1 << (14 - 2 * k));
         end else begin
            res_a = res_a >> 1;
         end
      end
   end

   always_comb begin
      rem_b = rem_ff;
      res_b = res_ff;
      trial_b = '0;
      for (int k = 4; k < 8; k++) begin
         trial_b = res_b + (17'd1 << (14 - 2 * k));
         if ({1'b0, rem_b} >= trial_b) begin
            rem_b = rem_b - trial_b[15:0];
            res_b = (res_b >> 1) + (17'd1 << (14 - 2 * k));
         end else begin
            res_b = res_b >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= q_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff   <= qx[10] ? 8'(-qx) : qx[7:0];
         ay_ff   <= qy[10] ? 8'(-qy) : qy[7:0];
         row1_ff <= q_item.row;
         col1_ff <= q_item.col;
         sum_ff  <= {1'b0, {8'b0, ax_ff} * {8'b0, ax_ff}}
                    + {1'b0, {8'b0, ay_ff} * {8'b0, ay_ff}};
         row2_ff <= row1_ff;
         col2_ff <= col1_ff;
         sat_ff  <= sum_ff[16];
         rem_ff  <= rem_a;
         res_ff  <= res_a;
         row3_ff <= row2_ff;
         col3_ff <= col2_ff;
         mag_ff  <= sat_ff ? 8'hFF : res_b[7:0];
         row4_ff <= row3_ff;
         col4_ff <= col3_ff;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_mag    = mag_ff;
   assign rsp_row    = row4_ff;
   assign rsp_col    = col4_ff;

endmodule

[hw/rtl/sobel_gradient_magnitude_3x3_unit.sv]
// 3x3 sobel gradient magnitude over a raster stream of 8-bit grey pixels. one pixel item is
// taken per clock while req_tready is high; each interior pixel yields one item
// floor(sqrt(gx^2+gy^2)) saturated at 255, with gx, gy the sobel sums divided by 4 toward zero,
// tagged with the centre row and column. border pixels give no item. req_tuser high marks the
// first pixel of a frame. csr_tdata sets the line width (3..2048, clamped); write it only while
// the block is idle. the front end (counters, two line-store rams, window) takes one item per
// cycle while req_tready is high, limited by the single read port of each line store; results
// pass a 4-entry queue into a 4-stage magnitude pipeline, and a stalled output backs up the
// queue before req_tready drops. line stores come up unwritten and need no clearing pass.
module sobel_gradient_magnitude_3x3_unit import sgm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata,   // [11:0] line_width
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [7:0] magnitude, [19:8] center_row, [30:20] center_col
);

   queue_status_type q_status;
   window_item_type  push_item, head_item;
   logic             q_push, q_pop;
   logic [PIX_W-1:0] mag;
   logic [ROW_W-1:0] row;
   logic [COL_W-1:0] col;

   // counters, line stores and window
   sgm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   // windows waiting for the magnitude pipeline
   sgm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   // sums, squares, root and output register
   sgm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_status.valid),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_mag    (mag),
      .rsp_row    (row),
      .rsp_col    (col)
   );

   assign rsp_tdata = {1'b0, col, row, mag};

endmodule

[tb/tb_sobel_gradient_magnitude_3x3_unit.sv]
module tb_sobel_gradient_magnitude_3x3_unit;
   import sgm_pkg::*;

   // pending pixel item for the driver
   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } pixel_item_type;

   // predicted gradient item
   typedef struct {
      logic [PIX_W-1:0] magnitude;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } gradient_item_type;

   localparam int IDLE_LIMIT = 5000;  // cycles with no handshake before giving up
   localparam int DRAIN_WAIT = 12;    // extra wait once every predicted item has been checked

   logic        clock;
   logic        reset;
   logic        csr_tvalid;
   logic        csr_tready;
   logic [15:0] csr_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   pixel_item_type    pixel_q[$];
   gradient_item_type gradient_q[$];

   // idle and stall percentages of the current phase
   int send_idle_pct;
   int recv_stall_pct;
   int error_count;
   int pixel_count;
   int gradient_count;
   int idle_cycles;

   // predictor state
   logic [PIX_W-1:0] upper_line[MAX_WIDTH];
   logic [PIX_W-1:0] middle_line[MAX_WIDTH];
   logic [PIX_W-1:0] win_px[3][3];
   logic [ROW_W-1:0] row_cnt;
   logic [COL_W-1:0] col_cnt;
   logic [CFG_W-1:0] width_reg;

   sobel_gradient_magnitude_3x3_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // width after clamping into the legal range
   function automatic int clamp_width(logic [CFG_W-1:0] value);
      int w;
      w = value;
      if (w < WIDTH_MIN) w = WIDTH_MIN;
      if (w > WIDTH_MAX) w = WIDTH_MAX;
      return w;
   endfunction

   function automatic logic [PIX_W-1:0] root_saturated(int unsigned v);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return (r > 255) ? 8'd255 : r[PIX_W-1:0];
   endfunction

   task automatic advance_row();
      col_cnt = '0;
      row_cnt = row_cnt + 1'b1;
   endtask

   // one pixel into the sobel predictor, maybe one gradient item out
   task automatic predict_gradient(pixel_item_type it);
      int                w;
      int                c;
      int                gx;
      int                gy;
      gradient_item_type g;
      w = clamp_width(width_reg);
      if (it.frame_start) begin
         row_cnt = '0;
         col_cnt = '0;
      end
      // width shrunk under the current column: wrap first
      if (int'(col_cnt) >= w) advance_row();
      c = col_cnt;
      for (int i = 0; i < 3; i++) begin
         win_px[i][0] = win_px[i][1];
         win_px[i][1] = win_px[i][2];
      end
      win_px[0][2] = upper_line[c];
      win_px[1][2] = middle_line[c];
      win_px[2][2] = it.pixel;
      upper_line[c] = middle_line[c];
      middle_line[c] = it.pixel;
      if (row_cnt >= 2 && c >= 2) begin
         gx = int'(win_px[0][0]) - int'(win_px[0][2])
            + 2 * int'(win_px[1][0]) - 2 * int'(win_px[1][2])
            + int'(win_px[2][0]) - int'(win_px[2][2]);
         gy = int'(win_px[2][0]) + 2 * int'(win_px[2][1]) + int'(win_px[2][2])
            - int'(win_px[0][0]) - 2 * int'(win_px[0][1]) - int'(win_px[0][2]);
         gx = gx / 4;  // truncates toward zero
         gy = gy / 4;
         g.magnitude = root_saturated(gx * gx + gy * gy);
         g.row = row_cnt - 1'b1;
         g.col = col_cnt - 1'b1;
         gradient_q.push_back(g);
      end
      if (int'(col_cnt) + 1 >= w) advance_row();
      else col_cnt = col_cnt + 1'b1;
   endtask

   // driver: next pixel item once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pixel_q[0].pixel;
            req_tuser  <= pixel_q[0].frame_start;
            void'(pixel_q.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver back pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: predict on accepted pixels, check accepted gradients, watchdog
   always @(posedge clock) begin
      gradient_item_type g;
      pixel_item_type    it;
      if (!reset) begin
         if (csr_tvalid && csr_tready) width_reg = csr_tdata[CFG_W-1:0];
         if (req_tvalid && req_tready) begin
            it.pixel = req_tdata;
            it.frame_start = req_tuser;
            predict_gradient(it);
            pixel_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            gradient_count++;
            if (gradient_q.size() == 0) begin
               $display("%0t: unexpected item, actual %h", $realtime, rsp_tdata);
               error_count++;
            end else begin
               g = gradient_q.pop_front();
               if (rsp_tdata[7:0] !== g.magnitude || rsp_tdata[19:8] !== g.row
                   || rsp_tdata[30:20] !== g.col) begin
                  $display("%0t: expected mag %0d row %0d col %0d, actual mag %0d row %0d col %0d",
                           $realtime, g.magnitude, g.row, g.col,
                           rsp_tdata[7:0], rsp_tdata[19:8], rsp_tdata[30:20]);
                  error_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_tvalid && csr_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("sobel_gradient_magnitude_3x3_unit: mismatch");
               $finish;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pixel_q.size() > 0 || req_tvalid || gradient_q.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // width writes happen only with the pipeline empty
   task automatic write_width(logic [CFG_W-1:0] value);
      wait_drained();
      csr_tvalid <= 1'b1;
      csr_tdata  <= {4'b0, value};
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid <= 1'b0;
   endtask

   task automatic queue_pixel(logic [PIX_W-1:0] px, logic fs);
      pixel_item_type it;
      it.pixel = px;
      it.frame_start = fs;
      pixel_q.push_back(it);
   endtask

   initial begin
      logic [CFG_W-1:0] widths[10];
      int w;
      int n;
      int style;
      widths = '{12'd0, 12'd7, 12'd3, 12'd16, 12'd2,
                 12'd33, 12'd4095, 12'd5, 12'd60, 12'd9};
      reset = 1'b1;
      csr_tvalid = 1'b0;
      csr_tdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      error_count = 0;
      pixel_count = 0;
      gradient_count = 0;
      idle_cycles = 0;
      width_reg = WIDTH_RESET;
      row_cnt = '0;
      col_cnt = '0;
      foreach (win_px[i, j]) win_px[i][j] = '0;
      foreach (upper_line[i]) begin
         upper_line[i] = '0;
         middle_line[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: narrowest image, strong vertical and horizontal edges, corners
      write_width(12'd3);
      queue_pixel(8'd255, 1'b1); queue_pixel(8'd0, 1'b0);   queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd255, 1'b0); queue_pixel(8'd0, 1'b0);   queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd255, 1'b0); queue_pixel(8'd0, 1'b0);   queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd0, 1'b0);   queue_pixel(8'd0, 1'b0);   queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd255, 1'b0); queue_pixel(8'd255, 1'b0); queue_pixel(8'd255, 1'b0);
      // frame restart in mid frame, then a corner that saturates
      queue_pixel(8'd255, 1'b1); queue_pixel(8'd255, 1'b0); queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd255, 1'b0); queue_pixel(8'd0, 1'b0);   queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd255, 1'b0); queue_pixel(8'd0, 1'b0);   queue_pixel(8'd0, 1'b0);

      // random phases over widths and idle patterns
      for (int p = 0; p < 10; p++) begin
         write_width(widths[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         w = clamp_width(widths[p]);
         // widest lines only check that nothing comes out in the first row
         n = (w > 100) ? 150 : 3 * w + 70;
         // new frame after every width change so no unwritten line entry is used
         for (int k = 0; k < n; k++) begin
            style = $urandom_range(9);
            queue_pixel((style < 2) ? {8{style[0]}} : 8'($urandom),
                        (k == 0) || ($urandom_range(199) == 0));
         end
      end

      // last phase: mid-line shrink without a frame restart
      write_width(12'd4);
      for (int k = 0; k < 60; k++) queue_pixel(8'($urandom), 1'b0);

      wait_drained();
      $display("ran %0d pixel items and %0d gradient items over %0d widths",
               pixel_count, gradient_count, 12);
      $display("phases mixed sender gaps and receiver stalls, errors %0d", error_count);
      if (error_count == 0) begin
         $display("sobel_gradient_magnitude_3x3_unit: match");
      end else begin
         $display("sobel_gradient_magnitude_3x3_unit: mismatch");
      end
      $finish;
   end

endmodule
